>>> design/iprt_pkg.sv
`default_nettype none
package iprt_pkg;

  // table geometry
  localparam int ROWS    = 32;
  localparam int SLOTS   = 4;
  localparam int ENTRIES = ROWS * SLOTS;
  localparam int ADDR_W  = $clog2(ENTRIES);

  // field widths
  localparam int KIND_W     = 2;
  localparam int ROW_W      = 5;
  localparam int SLOT_W     = 2;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 8;
  localparam int SPR_W      = 3;
  localparam int TMO_W      = 16;
  localparam int ST_W       = 2;
  localparam int SCAN_R_W   = ROW_W + 1;
  localparam int SCAN_S_W   = SPR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESPOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

  // slot status codes
  localparam logic [ST_W-1:0] ST_PENDING   = 2'd0;
  localparam logic [ST_W-1:0] ST_RESPONDED = 2'd1;
  localparam logic [ST_W-1:0] ST_TIMEOUT   = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  // config reset values
  localparam logic [ROW_W-1:0] LAST_ROW_RST  = 5'd29;
  localparam logic [SPR_W-1:0] SLOTS_ROW_RST = 3'd3;
  localparam logic [TMO_W-1:0] TIMEOUT_RST   = 16'd10000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_EVAL,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;        // capture item, apply record/respond, seed scan
    logic next_row;    // scan moves to slot 0 of next row
    logic issue_read;  // read table at scan position
    logic skip;        // non-pending slot passed
    logic calc_age;    // register age of pending slot
    logic fin_found;   // close check on a pending slot
    logic fin_done;    // close check with nothing pending
    logic emit;        // load output register
  } iprt_cmd_t;

  typedef struct packed {
    logic in_check;
    logic past_end;
    logic row_end;
    logic pending;
    logic out_busy;
  } iprt_sts_t;

endpackage
`default_nettype wire

>>> design/iprt_in_if.sv
`default_nettype none
interface iprt_in_if;
  import iprt_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ROW_W-1:0]    row;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, kind, row, slot, now_ms, input ready);
  modport sink   (input valid, kind, row, slot, now_ms, output ready);
endinterface
`default_nettype wire

>>> design/iprt_out_if.sv
`default_nettype none
interface iprt_out_if;
  import iprt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   retired_count;
  logic [ROW_W-1:0]   oldest_row;
  logic [SLOT_W-1:0]  oldest_slot;
  logic               timed_out;
  logic               all_done;

  modport source (output valid, retired_count, oldest_row, oldest_slot, timed_out,
                  all_done, input ready);
  modport sink   (input valid, retired_count, oldest_row, oldest_slot, timed_out,
                  all_done, output ready);
endinterface
`default_nettype wire

>>> design/iprt_cfg_if.sv
`default_nettype none
interface iprt_cfg_if;
  import iprt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/iprt_ctrl.sv
`default_nettype none
module iprt_ctrl
  import iprt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire iprt_sts_t sts,
  output iprt_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = sts.in_check ? S_STEP : S_OUT;
        end
      end
      S_STEP: begin
        if (sts.past_end) begin
          cmd.fin_done = 1'b1;
          state_next   = S_OUT;
        end else if (sts.row_end) begin
          cmd.next_row = 1'b1;
        end else begin
          cmd.issue_read = 1'b1;
          state_next     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.pending) begin
          cmd.calc_age = 1'b1;
          state_next   = S_DECIDE;
        end else begin
          cmd.skip   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_DECIDE: begin
        cmd.fin_found = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/iprt_dp.sv
`default_nettype none
module iprt_dp
  import iprt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire iprt_cmd_t              cmd,
  output iprt_sts_t                   sts,
  // item payload
  input  wire logic [KIND_W-1:0]      in_kind,
  input  wire logic [ROW_W-1:0]       in_row,
  input  wire logic [SLOT_W-1:0]      in_slot,
  input  wire logic [TIME_W-1:0]      in_now,
  // config writes
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // result register
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CNT_W-1:0]            out_count,
  output logic [ROW_W-1:0]            out_row,
  output logic [SLOT_W-1:0]           out_slot,
  output logic                        out_tout,
  output logic                        out_done
);

  // config
  logic [ROW_W-1:0] last_row_index;
  logic [SPR_W-1:0] slots_per_row;
  logic [TMO_W-1:0] timeout_ms;

  // tables; valid bit clear means entry still holds its reset value
  logic [ST_W-1:0]   stat_mem [ENTRIES];
  logic [TIME_W-1:0] time_mem [ENTRIES];
  logic [ENTRIES-1:0] stat_vld;
  logic [ENTRIES-1:0] time_vld;

  logic [ST_W-1:0]   stat_rd;
  logic [TIME_W-1:0] time_rd;
  logic              stat_rd_v;
  logic              time_rd_v;
  logic [ADDR_W-1:0] addr_q;

  // check state
  logic [TIME_W-1:0]   now_q;
  logic [SCAN_R_W-1:0] scan_r;
  logic [SCAN_S_W-1:0] scan_s;
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   age_q;
  logic                tout_q;
  logic                done_q;
  logic [ROW_W-1:0]    cursor_row;
  logic [SLOT_W-1:0]   cursor_slot;

  logic [ROW_W-1:0]    lastr;
  logic [SPR_W-1:0]    spr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_hit;
  logic                expired;
  logic [SCAN_S_W-1:0] nfs;
  logic [ST_W-1:0]     stat_eff;
  logic [TIME_W-1:0]   time_eff;
  logic                wr_stat;
  logic                wr_time;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ST_W-1:0]     wr_stat_data;

  always_comb begin
    lastr = last_row_index;
    if (int'(last_row_index) > ROWS - 1) begin
      lastr = ROW_W'(ROWS - 1);
    end
    spr = slots_per_row;
    if (int'(slots_per_row) > SLOTS) begin
      spr = SPR_W'(SLOTS);
    end
  end

  assign rd_addr  = ADDR_W'(int'(scan_r) * SLOTS + int'(scan_s));
  assign in_addr  = ADDR_W'(int'(in_row) * SLOTS + int'(in_slot));
  assign in_hit   = (int'(in_row) < ROWS) && (int'(in_slot) < SLOTS);
  assign stat_eff = stat_rd_v ? stat_rd : ST_PENDING;
  assign time_eff = time_rd_v ? time_rd : '0;
  assign expired  = age_q > TIME_W'(timeout_ms);
  assign nfs      = scan_s + SCAN_S_W'(1);

  assign sts.in_check = (in_kind == KIND_CHECK);
  assign sts.past_end = scan_r > {1'b0, lastr};
  assign sts.row_end  = scan_s >= spr;
  assign sts.pending  = (stat_eff == ST_PENDING);
  assign sts.out_busy = out_valid && !out_ready;

  // single write port: item update at load, timeout mark at close
  always_comb begin
    wr_stat      = 1'b0;
    wr_time      = 1'b0;
    wr_addr      = in_addr;
    wr_stat_data = ST_PENDING;
    if (cmd.load && in_hit) begin
      if (in_kind == KIND_RECORD) begin
        wr_stat = 1'b1;
        wr_time = 1'b1;
      end else if (in_kind == KIND_RESPOND) begin
        wr_stat      = 1'b1;
        wr_stat_data = ST_RESPONDED;
      end
    end else if (cmd.fin_found && expired) begin
      wr_stat      = 1'b1;
      wr_addr      = addr_q;
      wr_stat_data = ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_stat) begin
      stat_mem[wr_addr] <= wr_stat_data;
    end
    if (wr_time) begin
      time_mem[wr_addr] <= in_now;
    end
    if (cmd.issue_read) begin
      stat_rd <= stat_mem[rd_addr];
      time_rd <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_vld <= '0;
      time_vld <= '0;
    end else begin
      if (wr_stat) begin
        stat_vld[wr_addr] <= 1'b1;
      end
      if (wr_time) begin
        time_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      addr_q    <= rd_addr;
      stat_rd_v <= stat_vld[rd_addr];
      time_rd_v <= time_vld[rd_addr];
    end
    if (cmd.load) begin
      now_q <= in_now;
    end
    if (cmd.calc_age) begin
      age_q <= now_q - time_eff;
    end
  end

  // config, cursor, scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      last_row_index <= LAST_ROW_RST;
      slots_per_row  <= SLOTS_ROW_RST;
      timeout_ms     <= TIMEOUT_RST;
      cursor_row     <= '0;
      cursor_slot    <= '0;
      scan_r         <= '0;
      scan_s         <= '0;
      cnt            <= '0;
      tout_q         <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LAST_ROW:  last_row_index <= cfg_data[ROW_W-1:0];
          CFG_SLOTS_ROW: slots_per_row  <= cfg_data[SPR_W-1:0];
          CFG_TIMEOUT:   timeout_ms     <= cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        scan_r <= {1'b0, cursor_row};
        scan_s <= {1'b0, cursor_slot};
        cnt    <= '0;
        tout_q <= 1'b0;
        done_q <= 1'b0;
      end
      if (cmd.next_row) begin
        scan_r <= scan_r + SCAN_R_W'(1);
        scan_s <= '0;
      end
      if (cmd.skip) begin
        scan_s <= nfs;
        cnt    <= cnt + CNT_W'(1);
      end
      if (cmd.fin_found) begin
        if (expired) begin
          tout_q <= 1'b1;
          cnt    <= cnt + CNT_W'(1);
          if (nfs >= spr) begin
            cursor_row  <= ROW_W'(scan_r + SCAN_R_W'(1));
            cursor_slot <= '0;
          end else begin
            cursor_row  <= scan_r[ROW_W-1:0];
            cursor_slot <= nfs[SLOT_W-1:0];
          end
        end else begin
          cursor_row  <= scan_r[ROW_W-1:0];
          cursor_slot <= scan_s[SLOT_W-1:0];
        end
      end
      if (cmd.fin_done) begin
        done_q <= 1'b1;
        if (cursor_row <= lastr) begin
          cursor_row  <= lastr + ROW_W'(1);
          cursor_slot <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count <= cnt;
      out_row   <= cursor_row;
      out_slot  <= cursor_slot;
      out_tout  <= tout_q;
      out_done  <= done_q;
    end
  end

endmodule
`default_nettype wire

>>> design/inorder_probe_retire_tracker_top.sv
`default_nettype none
// Record, respond and spare items: loaded into the output register from S_OUT after transfer in.
// Check items: scan from the cursor through S_STEP and S_EVAL to the first pending slot or end.
// One item in flight; the next transfer is taken the cycle after the result is loaded, and
// a stalled result transfer holds off the load.
// Reset (rst, synchronous, high): cursor to row 0 slot 0, config to defaults, every slot
// pending with send time zero via per-entry valid bits; no transfer taken while in reset.
module inorder_probe_retire_tracker_top
  import iprt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  iprt_in_if.sink   probe,
  iprt_out_if.source result,
  iprt_cfg_if.sink  cfg
);

  iprt_cmd_t cmd;
  iprt_sts_t sts;

  // config writes go straight into the config registers, accepted whenever out of reset
  assign cfg.ready = !rst;

  // sequencer: walks the table one slot at a time on a check
  iprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (probe.valid),
    .in_ready (probe.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, cursor, config registers and output register
  iprt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (probe.kind),
    .in_row    (probe.row),
    .in_slot   (probe.slot),
    .in_now    (probe.now_ms),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_count (result.retired_count),
    .out_row   (result.oldest_row),
    .out_slot  (result.oldest_slot),
    .out_tout  (result.timed_out),
    .out_done  (result.all_done)
  );

endmodule
`default_nettype wire
